/* hdl/gf128_multiplier_unit_macros.svh */
// Assertion macros shared by the GF(2^128) multiplier RTL.
`ifndef GF128_MULTIPLIER_UNIT_MACROS_SVH
`define GF128_MULTIPLIER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gf128m_pkg.sv */
// Package with widths and carry-less arithmetic helpers for the GF(2^128) multiplier.
`default_nettype none

package gf128m_pkg;

    localparam int WordW  = 64;
    localparam int HalfW  = 32;
    localparam int PartW  = HalfW + WordW - 1;
    localparam int FieldW = 2 * WordW;
    localparam int FullW  = 2 * FieldW;

    // Shifts of the reduction: x^128 == x^7 + x^2 + x + 1.
    localparam int Tap1 = 1;
    localparam int Tap2 = 2;
    localparam int Tap7 = 7;

    typedef logic [WordW-1:0]  word_t;
    typedef logic [PartW-1:0]  part_t;
    typedef logic [FieldW-1:0] field_t;
    typedef logic [FullW-1:0]  full_t;

    // Carry-less product of a 32-bit slice and a 64-bit word. Each result
    // bit is the parity of its own diagonal of partial-product bits.
    function automatic part_t clmul_part(input logic [HalfW-1:0] a, input word_t b);
        part_t            r;
        logic [HalfW-1:0] t;
        int               j;
        r = '0;
        for (int k = 0; k < PartW; k++)
        begin
            for (int i = 0; i < HalfW; i++)
            begin
                j = k - i;
                if (j >= 0 && j < WordW)
                    t[i] = a[i] & b[j[5:0]];
                else
                    t[i] = 1'b0;
            end
            r[k] = ^t;
        end
        return r;
    endfunction

    // Join the low and high slice products of one 64x64 carry-less multiply.
    function automatic field_t join_parts(input part_t lo, input part_t hi);
        return FieldW'(lo) ^ (FieldW'(hi) << HalfW);
    endfunction

    // Fold the upper half of the 256-bit product back twice.
    function automatic field_t gf_reduce(input full_t p);
        word_t p0, p1, p2, p3, fold, s0, s1;
        p0 = p[WordW-1:0];
        p1 = p[2*WordW-1:WordW];
        p2 = p[3*WordW-1:2*WordW];
        p3 = p[4*WordW-1:3*WordW];
        fold = p2 ^ (p3 >> (WordW - Tap1)) ^ (p3 >> (WordW - Tap2))
             ^ (p3 >> (WordW - Tap7));
        s1 = p3 ^ (p3 << Tap1) ^ (fold >> (WordW - Tap1))
                ^ (p3 << Tap2) ^ (fold >> (WordW - Tap2))
                ^ (p3 << Tap7) ^ (fold >> (WordW - Tap7));
        s0 = fold ^ (fold << Tap1) ^ (fold << Tap2) ^ (fold << Tap7);
        return {p1 ^ s1, p0 ^ s0};
    endfunction

endpackage

`default_nettype wire

/* hdl/gf128m_if.sv */
// Valid/ready stream interfaces for the operand and result channels.
`default_nettype none

interface gf128m_in_if
    import gf128m_pkg::*;
    ;
    logic  valid;
    logic  ready;
    word_t a_low;
    word_t a_high;
    word_t b_low;
    word_t b_high;

    modport source (output valid, a_low, a_high, b_low, b_high, input ready);
    modport sink   (input valid, a_low, a_high, b_low, b_high, output ready);
endinterface

interface gf128m_out_if
    import gf128m_pkg::*;
    ;
    logic  valid;
    logic  ready;
    word_t product_low;
    word_t product_high;

    modport source (output valid, product_low, product_high, input ready);
    modport sink   (input valid, product_low, product_high, output ready);
endinterface

`default_nettype wire

/* hdl/gf128_multiplier_unit.sv */
// Top level of the pipelined GF(2^128) multiplier.
`default_nettype none
`include "gf128_multiplier_unit_macros.svh"

// Multiplies two elements of GF(2^128), plain bit order, modulo
// x^128 + x^7 + x^2 + x + 1. The pipeline has three register stages: the
// first holds the carry-less slice products (each 64x64 multiply split into
// two 32-bit halves of the first operand), the second the joined 255-bit
// product, and the third the reduced result, which is also the output
// register. An operand passes the slice, product and result registers in turn
// before its result is offered, and one operand is taken every cycle while
// results drain; a stall on the result side holds every stage in place and
// fills any bubbles before it pushes back on the operand side. There is no
// state beyond the pipeline, so nothing needs configuring or clearing.
module gf128_multiplier_unit
    import gf128m_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gf128m_in_if.sink   operand,
    gf128m_out_if.source result
);

    logic   v1_reg, v2_reg, v3_reg;
    logic   en1, en2, en3;

    part_t  ll_lo_reg, ll_hi_reg, mid_lo_reg, mid_hi_reg, hh_lo_reg, hh_hi_reg;
    part_t  ll_lo_next, ll_hi_next, mid_lo_next, mid_hi_next, hh_lo_next, hh_hi_next;
    full_t  full_reg, full_next;
    field_t res_reg, res_next;

    // Each stage moves when it is empty or the stage after it moves.
    assign en3 = !v3_reg || result.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign operand.ready       = en1;
    assign result.valid        = v3_reg;
    assign result.product_low  = res_reg[WordW-1:0];
    assign result.product_high = res_reg[FieldW-1:WordW];

    // Stage 1: slice products; the two cross terms are summed at once.
    always_comb
    begin
        ll_lo_next  = clmul_part(operand.a_low[HalfW-1:0], operand.b_low);
        ll_hi_next  = clmul_part(operand.a_low[WordW-1:HalfW], operand.b_low);
        hh_lo_next  = clmul_part(operand.a_high[HalfW-1:0], operand.b_high);
        hh_hi_next  = clmul_part(operand.a_high[WordW-1:HalfW], operand.b_high);
        mid_lo_next = clmul_part(operand.a_low[HalfW-1:0], operand.b_high)
                    ^ clmul_part(operand.a_high[HalfW-1:0], operand.b_low);
        mid_hi_next = clmul_part(operand.a_low[WordW-1:HalfW], operand.b_high)
                    ^ clmul_part(operand.a_high[WordW-1:HalfW], operand.b_low);
    end

    // Stage 2: join the slices into the full carry-less product.
    always_comb
    begin
        full_next = FullW'(join_parts(ll_lo_reg, ll_hi_reg))
                  ^ (FullW'(join_parts(mid_lo_reg, mid_hi_reg)) << WordW)
                  ^ (FullW'(join_parts(hh_lo_reg, hh_hi_reg)) << FieldW);
    end

    // Stage 3: reduce modulo the field polynomial.
    assign res_next = gf_reduce(full_reg);

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= operand.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // Payload registers load only when their stage moves.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ll_lo_reg  <= ll_lo_next;
            ll_hi_reg  <= ll_hi_next;
            mid_lo_reg <= mid_lo_next;
            mid_hi_reg <= mid_hi_next;
            hh_lo_reg  <= hh_lo_next;
            hh_hi_reg  <= hh_hi_next;
        end
        if (en2)
            full_reg <= full_next;
        if (en3)
            res_reg <= res_next;
    end

    // Back pressure reaches the operand side only with a full first stage.
    `GFM_ASSERT_SAME(a_ready_full, clk, rst_n, !operand.ready, v1_reg, "operand stalled with stage 1 empty")
    // A stage that moves hands its item on.
    `GFM_ASSERT_NEXT(a_s1_moves, clk, rst_n, v1_reg && en2, v2_reg, "stage 1 item lost")
    // A blocked stage keeps its item.
    `GFM_ASSERT_NEXT(a_s2_holds, clk, rst_n, v2_reg && !en3, v2_reg && $stable(full_reg), "stage 2 item lost in stall")
    // The carry-less product of two degree-127 polynomials has degree at most 254.
    `GFM_ASSERT_SAME(a_deg_bound, clk, rst_n, v2_reg, !full_reg[FullW-1], "product degree above 254")
    // A zero product reduces to zero.
    `GFM_ASSERT_NEXT(a_zero_red, clk, rst_n, v2_reg && en3 && (full_reg == '0), res_reg == '0, "zero product reduced to nonzero")

endmodule

`default_nettype wire
